// ----- rtl/core/mtfm_pkg.sv -----
// Shared types and constants for the MQTT topic filter match unit.
// Holds the controller/datapath command and status structs and the character codes.
// No dependencies.
`timescale 1ns / 1ps

package mtfm_pkg;

  // Characters with a special meaning in topic filters.
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_NO_FILTER = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;    // accept input transactions
    logic rd_pair;     // read topic byte and filter bytes at the current position
    logic fetch_next;  // capture current bytes, read the filter look-ahead
    logic eval_wild;   // evaluate one wildcard match step
    logic scan_rd;     // read the next topic byte of a '+' level scan
    logic scan_chk;    // check the scanned topic byte
    logic push;        // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic topic_end;   // last topic byte accepted this cycle
    logic walk;        // the match needs a walk over the stores
    logic wild;        // wildcard mode of the current topic
    logic done;        // result decided this cycle
    logic scan;        // a '+' level scan starts
    logic more;        // the walk continues at the next position
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

// ----- rtl/core/mtfm_if.sv -----
// Valid/ready channel interfaces for the MQTT topic filter match unit.
// Input channel carries filter/topic bytes, output channel carries match results.
// No dependencies.
`timescale 1ns / 1ps

interface mtfm_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       use_wildcards;

  modport source (output valid, output mode, output data_byte, output last_byte,
                  output use_wildcards, input ready);
  modport sink   (input valid, input mode, input data_byte, input last_byte,
                  input use_wildcards, output ready);
endinterface

interface mtfm_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic [1:0] status;

  modport source (output valid, output matched, output status, input ready);
  modport sink   (input valid, input matched, input status, output ready);
endinterface

// ----- rtl/core/mtfm_datapath.sv -----
// Datapath of the MQTT topic filter match unit: filter and topic stores,
// walk pointers, match step evaluation and the output register.
// Depends on mtfm_pkg and the channel interfaces in mtfm_if.sv.
`timescale 1ns / 1ps

module mtfm_datapath #(
  parameter int MAX_LEN = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mtfm_in_if.sink           in_i,
  mtfm_out_if.source        out_o,
  input  mtfm_pkg::cmd_t    cmd_i,
  output mtfm_pkg::sts_t    sts_o
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam logic [LW-1:0] MaxLen = LW'(MAX_LEN);

  // Byte stores, written on input transactions, read with registered data.
  logic [7:0] fmem [MAX_LEN];
  logic [7:0] tmem [MAX_LEN];

  logic [LW-1:0] flen_q, flen_d, tlen_q, tlen_d;
  logic          fcomp_q, fcomp_d, fovf_q, fovf_d, tovf_q, tovf_d;
  logic [LW-1:0] ti_q, ti_d, fi_q, fi_d;
  logic          first_q, first_d, wild_q, wild_d, fmore_q, fmore_d;
  logic          res_match_q, res_match_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [7:0]    tq, fq1, fq2;
  logic [7:0]    fcur_q, fcur_d, fprev_q, fprev_d;
  logic          out_valid_q, out_valid_d, out_match_q, out_match_d;
  logic [1:0]    out_status_q, out_status_d;

  logic          in_fire, out_free, t_rd_en, f_rd_en;
  logic [AW-1:0] ta, fa1, fa2;
  logic [LW-1:0] fwidx, tl_new;
  logic [LW:0]   ti_x, fi_x, tl_x, fl_x, ti_p1, fi_p1, fi_p2, fi_p3;
  logic [1:0]    st_new;
  logic          found, at_level;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_free = ~out_valid_q | out_o.ready;

  assign in_i.ready    = cmd_i.in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.matched = out_match_q;
  assign out_o.status  = out_status_q;

  // Widened positions for compares that may reach the string lengths.
  assign ti_x  = {1'b0, ti_q};
  assign fi_x  = {1'b0, fi_q};
  assign tl_x  = {1'b0, tlen_q};
  assign fl_x  = {1'b0, flen_q};
  assign ti_p1 = ti_x + (LW+1)'(1);
  assign fi_p1 = fi_x + (LW+1)'(1);
  assign fi_p2 = fi_x + (LW+1)'(2);
  assign fi_p3 = fi_x + (LW+1)'(3);

  // Write positions and the topic length after the current byte.
  assign fwidx  = fcomp_q ? '0 : flen_q;
  assign tl_new = (tlen_q < MaxLen) ? LW'(tlen_q + LW'(1)) : tlen_q;

  // Read address selection.
  always_comb begin
    t_rd_en = cmd_i.rd_pair | cmd_i.scan_rd;
    f_rd_en = cmd_i.rd_pair | cmd_i.fetch_next;
    ta      = ti_q[AW-1:0];
    if (cmd_i.rd_pair) begin
      fa1 = fi_q[AW-1:0];
      fa2 = fi_q[AW-1:0] - AW'(1);
    end else begin
      fa1 = fi_q[AW-1:0] + AW'(1);
      fa2 = fi_q[AW-1:0] + AW'(2);
    end
  end

  // Store writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (in_fire && !in_i.mode && (fwidx < MaxLen)) begin
      fmem[fwidx[AW-1:0]] <= in_i.data_byte;
    end
    if (in_fire && in_i.mode && (tlen_q < MaxLen)) begin
      tmem[tlen_q[AW-1:0]] <= in_i.data_byte;
    end
    if (t_rd_en) begin
      tq <= tmem[ta];
    end
    if (f_rd_en) begin
      fq1 <= fmem[fa1];
      fq2 <= fmem[fa2];
    end
  end

  // Tail checks for a topic that ends on an equal byte.
  always_comb begin
    found = 1'b0;
    if (ti_p1 == tl_x) begin
      if (fi_p2 == fl_x && fcur_q == mtfm_pkg::CH_SLASH) begin
        found = (fq1 == mtfm_pkg::CH_PLUS) || (fq1 == mtfm_pkg::CH_HASH);
      end else begin
        found = (fi_p3 == fl_x) && (fq1 == mtfm_pkg::CH_SLASH) &&
                (fq2 == mtfm_pkg::CH_HASH);
      end
    end
  end

  assign at_level = (fi_q == '0) || (fprev_q == mtfm_pkg::CH_SLASH);

  // Status of a finished topic.
  always_comb begin
    if (fovf_q || tovf_q || (tlen_q == MaxLen)) begin
      st_new = mtfm_pkg::STATUS_OVERFLOW;
    end else if (flen_q == '0) begin
      st_new = mtfm_pkg::STATUS_NO_FILTER;
    end else begin
      st_new = mtfm_pkg::STATUS_OK;
    end
  end

  // Next-state logic of the datapath registers.
  always_comb begin
    flen_d       = flen_q;
    fcomp_d      = fcomp_q;
    fovf_d       = fovf_q;
    tlen_d       = tlen_q;
    tovf_d       = tovf_q;
    ti_d         = ti_q;
    fi_d         = fi_q;
    first_d      = first_q;
    wild_d       = wild_q;
    fmore_d      = fmore_q;
    res_match_d  = res_match_q;
    res_status_d = res_status_q;
    fcur_d       = fcur_q;
    fprev_d      = fprev_q;
    out_valid_d  = out_valid_q;
    out_match_d  = out_match_q;
    out_status_d = out_status_q;
    sts_o        = '0;
    sts_o.wild     = wild_q;
    sts_o.out_free = out_free;

    // Output register: drain on a transaction, load on a push.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.push && out_free) begin
      out_valid_d  = 1'b1;
      out_match_d  = res_match_q;
      out_status_d = res_status_q;
      tlen_d       = '0;
      tovf_d       = 1'b0;
    end

    // Input transactions: store the byte, and on a topic end set up the match.
    if (in_fire) begin
      if (!in_i.mode) begin
        if (fcomp_q) begin
          fovf_d = 1'b0;
        end
        if (fwidx < MaxLen) begin
          flen_d = LW'(fwidx + LW'(1));
        end else begin
          flen_d = fwidx;
          fovf_d = 1'b1;
        end
        fcomp_d = in_i.last_byte;
      end else begin
        tlen_d = tl_new;
        if (tlen_q == MaxLen) begin
          tovf_d = 1'b1;
        end
        if (in_i.last_byte) begin
          sts_o.topic_end = 1'b1;
          sts_o.walk      = (st_new == mtfm_pkg::STATUS_OK) &&
                            (in_i.use_wildcards || (tl_new == flen_q));
          res_status_d    = st_new;
          res_match_d     = 1'b0;
          wild_d          = in_i.use_wildcards;
          ti_d            = '0;
          fi_d            = '0;
          first_d         = 1'b1;
        end
      end
    end

    // Exact compare step, or capture of the current wildcard bytes.
    if (cmd_i.fetch_next) begin
      if (wild_q) begin
        fcur_d  = fq1;
        fprev_d = fq2;
      end else if (tq != fq1) begin
        sts_o.done  = 1'b1;
        res_match_d = 1'b0;
      end else if (ti_p1 == tl_x) begin
        sts_o.done  = 1'b1;
        res_match_d = 1'b1;
      end else begin
        sts_o.more = 1'b1;
        ti_d       = LW'(ti_p1);
        fi_d       = LW'(fi_p1);
      end
    end

    // One wildcard match step.
    if (cmd_i.eval_wild) begin
      first_d = 1'b0;
      if (first_q && tq == mtfm_pkg::CH_DOLLAR &&
          (fcur_q == mtfm_pkg::CH_PLUS || fcur_q == mtfm_pkg::CH_HASH)) begin
        sts_o.done  = 1'b1;
        res_match_d = 1'b0;
      end else if (tq == fcur_q) begin
        if (found) begin
          sts_o.done  = 1'b1;
          res_match_d = 1'b1;
        end else if (ti_p1 < tl_x && fi_p1 < fl_x) begin
          sts_o.more = 1'b1;
          ti_d       = LW'(ti_p1);
          fi_d       = LW'(fi_p1);
        end else begin
          sts_o.done  = 1'b1;
          res_match_d = (ti_p1 == tl_x) && (fi_p1 == fl_x);
        end
      end else if (fcur_q == mtfm_pkg::CH_PLUS && at_level) begin
        sts_o.scan = 1'b1;
        fmore_d    = (fi_p1 < fl_x) && (fq1 == mtfm_pkg::CH_SLASH);
      end else if (fcur_q == mtfm_pkg::CH_HASH && fi_p1 == fl_x && at_level) begin
        sts_o.done  = 1'b1;
        res_match_d = 1'b1;
      end else begin
        sts_o.done  = 1'b1;
        res_match_d = 1'b0;
      end
    end

    // One byte of a '+' level scan over the topic.
    if (cmd_i.scan_chk) begin
      if (tq == mtfm_pkg::CH_SLASH) begin
        if (!fmore_q) begin
          sts_o.done  = 1'b1;
          res_match_d = 1'b0;
        end else if (ti_p1 < tl_x && fi_p2 < fl_x) begin
          sts_o.more = 1'b1;
          ti_d       = LW'(ti_p1);
          fi_d       = LW'(fi_p2);
        end else begin
          sts_o.done  = 1'b1;
          res_match_d = (ti_p1 == tl_x) && (fi_p2 == fl_x);
        end
      end else if (ti_p1 == tl_x) begin
        sts_o.done  = 1'b1;
        res_match_d = (fi_p1 == fl_x);
      end else begin
        ti_d = LW'(ti_p1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flen_q      <= '0;
      fcomp_q     <= 1'b0;
      fovf_q      <= 1'b0;
      tlen_q      <= '0;
      tovf_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      flen_q      <= flen_d;
      fcomp_q     <= fcomp_d;
      fovf_q      <= fovf_d;
      tlen_q      <= tlen_d;
      tovf_q      <= tovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk and result payload registers.
  always_ff @(posedge clk_i) begin
    ti_q         <= ti_d;
    fi_q         <= fi_d;
    first_q      <= first_d;
    wild_q       <= wild_d;
    fmore_q      <= fmore_d;
    res_match_q  <= res_match_d;
    res_status_q <= res_status_d;
    fcur_q       <= fcur_d;
    fprev_q      <= fprev_d;
    out_match_q  <= out_match_d;
    out_status_q <= out_status_d;
  end

endmodule

// ----- rtl/core/mtfm_ctrl.sv -----
// Controller of the MQTT topic filter match unit: sequences byte loading,
// the exact or wildcard walk, '+' level scans and the result hand-off.
// Depends on mtfm_pkg.
`timescale 1ns / 1ps

module mtfm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mtfm_pkg::sts_t sts_i,
  output mtfm_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RD     = 3'd1;
  localparam logic [2:0] ST_FETCH  = 3'd2;
  localparam logic [2:0] ST_EVAL   = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_SCHK   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0] state_q, state_d;

  // Command decode from the current state.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:  cmd_o.in_ready   = 1'b1;
      ST_RD:    cmd_o.rd_pair    = 1'b1;
      ST_FETCH: cmd_o.fetch_next = 1'b1;
      ST_EVAL:  cmd_o.eval_wild  = 1'b1;
      ST_SCAN:  cmd_o.scan_rd    = 1'b1;
      ST_SCHK:  cmd_o.scan_chk   = 1'b1;
      ST_DONE:  cmd_o.push       = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (sts_i.topic_end) begin
          state_d = sts_i.walk ? ST_RD : ST_DONE;
        end
      end
      ST_RD: state_d = ST_FETCH;
      ST_FETCH: begin
        if (sts_i.wild) begin
          state_d = ST_EVAL;
        end else begin
          state_d = sts_i.done ? ST_DONE : ST_RD;
        end
      end
      ST_EVAL: begin
        if (sts_i.done) begin
          state_d = ST_DONE;
        end else if (sts_i.scan) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_SCAN: state_d = ST_SCHK;
      ST_SCHK: begin
        if (sts_i.done) begin
          state_d = ST_DONE;
        end else if (sts_i.more) begin
          state_d = ST_RD;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/mqtt_topic_filter_match_unit.sv -----
// MQTT topic filter match unit. Filter and topic bytes load at one per cycle while the controller is idle.
// After the last topic byte the result goes straight to the output register when it follows
// from status or length; exact mode walks each byte through a read and a fetch, wildcard mode
// steps through read, fetch and evaluate, a '+' scan reads and checks each topic byte, then the result is handed off.
// Reset clears lengths, flags, controller and output valid; the byte stores are not cleared.
// Depends on mtfm_pkg, mtfm_if.sv, mtfm_ctrl and mtfm_datapath.
`timescale 1ns / 1ps

module mqtt_topic_filter_match_unit #(
  parameter int MAX_LEN = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtfm_in_if.sink    in_i,
  mtfm_out_if.source out_o
);

  mtfm_pkg::cmd_t cmd;
  mtfm_pkg::sts_t sts;

  // Controller state machine.
  mtfm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Stores, walk pointers and output register.
  mtfm_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  // A finished topic stops input until its result is handed off.
  a_topic_end_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.mode && in_i.last_byte) |=> !in_i.ready)
    else $error("input still accepted after a topic end");

  // A new result appears only while input is held off.
  a_result_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result appeared while input was open");

  // An error status never reports a match.
  a_status_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != mtfm_pkg::STATUS_OK) |-> !out_o.matched)
    else $error("match reported with error status");

  // Only defined status codes leave the block.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.status == mtfm_pkg::STATUS_OK ||
                     out_o.status == mtfm_pkg::STATUS_OVERFLOW ||
                     out_o.status == mtfm_pkg::STATUS_NO_FILTER))
    else $error("undefined status code");

endmodule
